### sv/gfm_pkg.sv
// ============================================================================
// gfm_pkg
// Shared widths, the reduction byte and the pipeline stage type for the
// GF(2^128) block multiplier.
// ============================================================================
package gfm_pkg;

  localparam int GFM_BLOCK_BYTES = 16;
  localparam int GFM_BLOCK_BITS  = GFM_BLOCK_BYTES * 8;
  localparam int GFM_HALF_W      = GFM_BLOCK_BITS / 2;

  // Default number of operand bits that one cell consumes
  localparam int GFM_STEPS_PER_CELL = 4;

  // Top byte of the reduction polynomial R = 0xE1 || 0^120
  localparam logic [7:0] GFM_REDUCE_TOP = 8'hE1;

  // One stage of the multiply chain: running product, shifted multiplicand,
  // and the operand bits still to be consumed (next bit at the MSB)
  typedef struct packed {
    logic                      valid;
    logic [GFM_BLOCK_BITS-1:0] z;
    logic [GFM_BLOCK_BITS-1:0] v;
    logic [GFM_BLOCK_BITS-1:0] x;
  } gfm_stage_t;

endpackage

### sv/gfm_operand_if.sv
// ============================================================================
// gfm_operand_if
// Valid/ready channel that carries the two 128-bit operands as halves.
// ============================================================================
interface gfm_operand_if;

  logic                          valid;
  logic                          ready;
  logic [gfm_pkg::GFM_HALF_W-1:0] x_upper;
  logic [gfm_pkg::GFM_HALF_W-1:0] x_lower;
  logic [gfm_pkg::GFM_HALF_W-1:0] y_upper;
  logic [gfm_pkg::GFM_HALF_W-1:0] y_lower;

  modport source (output valid, x_upper, x_lower, y_upper, y_lower, input ready);
  modport sink   (input valid, x_upper, x_lower, y_upper, y_lower, output ready);

endinterface

### sv/gfm_product_if.sv
// ============================================================================
// gfm_product_if
// Valid/ready channel that carries the 128-bit product as halves.
// ============================================================================
interface gfm_product_if;

  logic                          valid;
  logic                          ready;
  logic [gfm_pkg::GFM_HALF_W-1:0] product_upper;
  logic [gfm_pkg::GFM_HALF_W-1:0] product_lower;

  modport source (output valid, product_upper, product_lower, input ready);
  modport sink   (input valid, product_upper, product_lower, output ready);

endinterface

### sv/gfm_cell.sv
// ============================================================================
// gfm_cell
// One cell of the multiply chain: consumes STEPS operand bits, folds the
// multiplicand into the running product and registers the result.
// ============================================================================
module gfm_cell #(
  parameter int STEPS = gfm_pkg::GFM_STEPS_PER_CELL
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  gfm_pkg::gfm_stage_t prev,
  output gfm_pkg::gfm_stage_t stage
);
  import gfm_pkg::*;

  gfm_stage_t stage_next;

  // Walk the cell's operand bits, MSB first
  always_comb begin
    logic [GFM_BLOCK_BITS-1:0] z;
    logic [GFM_BLOCK_BITS-1:0] v;
    logic [GFM_BLOCK_BITS-1:0] x;
    logic                      carry;
    z = prev.z;
    v = prev.v;
    x = prev.x;
    for (int i = 0; i < STEPS; i++) begin
      if (x[GFM_BLOCK_BITS-1]) begin
        z = z ^ v;
      end
      carry = v[0];
      v = v >> 1;
      if (carry) begin
        v[GFM_BLOCK_BITS-1 -: 8] = v[GFM_BLOCK_BITS-1 -: 8] ^ GFM_REDUCE_TOP;
      end
      x = x << 1;
    end
    stage_next.valid = prev.valid;
    stage_next.z     = z;
    stage_next.v     = v;
    stage_next.x     = x;
  end

  // Advance the stage; reset drops the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage <= stage_next;
    end
  end

endmodule

### sv/gfm_out_buf.sv
// ============================================================================
// gfm_out_buf
// Output register with a skid entry: decouples the product channel from the
// chain so the chain keeps moving while one product waits, until the skid entry is full.
// ============================================================================
module gfm_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  gfm_pkg::gfm_stage_t last,
  output logic                chain_en,
  gfm_product_if.source       result
);
  import gfm_pkg::*;

  logic                      out_valid;
  logic [GFM_BLOCK_BITS-1:0] out_data;
  logic                      skid_valid;
  logic [GFM_BLOCK_BITS-1:0] skid_data;
  logic                      take;
  logic                      load_out_chain;
  logic                      load_out_skid;
  logic                      load_skid;

  assign chain_en = !skid_valid;
  assign take     = out_valid && result.ready;

  // Decide where a product from the chain or the skid entry lands
  always_comb begin
    load_out_skid  = skid_valid && take;
    load_out_chain = !skid_valid && last.valid && (!out_valid || take);
    load_skid      = !skid_valid && last.valid && out_valid && !take;
  end

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load_out_skid) begin
        skid_valid <= 1'b0;
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end
      if (load_out_chain || load_out_skid) begin
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold payloads
  always_ff @(posedge clk) begin
    if (load_out_skid) begin
      out_data <= skid_data;
    end else if (load_out_chain) begin
      out_data <= last.z;
    end
    if (load_skid) begin
      skid_data <= last.z;
    end
  end

  assign result.valid         = out_valid;
  assign result.product_upper = out_data[GFM_BLOCK_BITS-1:GFM_HALF_W];
  assign result.product_lower = out_data[GFM_HALF_W-1:0];

endmodule

### sv/gf128_block_multiply.sv
// Each operand pair passes through the registered cells of the chain and then
// the output register before the product is valid.
// Throughput: one operand pair per cycle while the skid entry is empty; the
// chain of cells is the only path. A stalled product parks in a skid entry;
// operands are refused only while that entry is full.
// Reset (synchronous, active high) empties the chain and the output buffer.
// ============================================================================
// gf128_block_multiply
// GCM GF(2^128) multiplier built as a chain of cells, each taking a slice of
// the X operand bits.
// ============================================================================
module gf128_block_multiply #(
  parameter int STEPS_PER_CELL = gfm_pkg::GFM_STEPS_PER_CELL
) (
  input  logic          clk,
  input  logic          rst,
  gfm_operand_if.sink   operands,
  gfm_product_if.source result
);
  import gfm_pkg::*;

  localparam int NUM_CELLS = GFM_BLOCK_BITS / STEPS_PER_CELL;

  gfm_stage_t chain [0:NUM_CELLS];
  logic       chain_en;

  // Feed the head of the chain from the operand channel
  always_comb begin
    chain[0].valid = operands.valid;
    chain[0].z     = '0;
    chain[0].v     = {operands.y_upper, operands.y_lower};
    chain[0].x     = {operands.x_upper, operands.x_lower};
  end

  assign operands.ready = chain_en;

  // Build the row of cells
  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    gfm_cell #(
      .STEPS (STEPS_PER_CELL)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (chain_en),
      .prev  (chain[c]),
      .stage (chain[c+1])
    );
  end

  gfm_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .last     (chain[NUM_CELLS]),
    .chain_en (chain_en),
    .result   (result)
  );

endmodule

### sv/gfm_checker.sv
// ============================================================================
// gfm_checker
// Port-level checks on the GF(2^128) multiplier's flow control.
// ============================================================================
module gfm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          op_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [gfm_pkg::GFM_HALF_W-1:0] res_upper,
  input logic [gfm_pkg::GFM_HALF_W-1:0] res_lower
);

  // Reset leaves no product pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("product valid right after reset");

  // A stalled product holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_upper) && $stable(res_lower))
    else $error("stalled product changed");

  // Operands are refused only while a product waits
  a_refuse: assert property (@(posedge clk) disable iff (rst)
    !op_ready |-> res_valid)
    else $error("operands refused with no product pending");

  // Refusal starts only after a product was stalled
  a_refuse_cause: assert property (@(posedge clk) disable iff (rst)
    !op_ready && !$past(rst) && $past(op_ready) |-> $past(res_valid && !res_ready))
    else $error("operands refused without a stalled product");

endmodule

bind gf128_block_multiply gfm_checker u_gfm_checker (
  .clk       (clk),
  .rst       (rst),
  .op_ready  (operands.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_upper (result.product_upper),
  .res_lower (result.product_lower)
);
